[sv/rcwt_pkg.sv]
// rcwt_pkg: shared types and codes for the rolling code window tracker.
// No dependencies; used by rcwt_check, rolling_code_window_tracker_core and the bench.
`default_nettype none

package rcwt_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_SYNC  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_SLOTS    = 2'd0;
  localparam logic [1:0] CFG_SYNC_MARGIN  = 2'd1;
  localparam logic [1:0] CFG_UNSET_MARKER = 2'd2;

  localparam logic [4:0]  NUM_SLOTS_RST    = 5'd16;
  localparam logic [31:0] SYNC_MARGIN_RST  = 32'd256;
  localparam logic [31:0] UNSET_MARKER_RST = 32'd0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_CLR  = 3'b100
  } state_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  command_out;
    logic        changed;
    logic [7:0]  changed_slot;
    logic [31:0] new_code;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [31:0] data;
  } update_t;

endpackage

`default_nettype wire

[sv/rcwt_slot_ram.sv]
// rcwt_slot_ram: slot code store, one write and one read port, registered read.
// Depends on nothing.
`default_nettype none

module rcwt_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/rcwt_check.sv]
// rcwt_check: window check, marker bump and result forming for one item.
// Depends on rcwt_pkg.
`default_nettype none

module rcwt_check (
  input  wire rcwt_pkg::op_t  op,
  input  wire logic           slot_ok,
  input  wire logic [7:0]     slot,
  input  wire logic [31:0]    code,
  input  wire logic [7:0]     command,
  input  wire logic [31:0]    last,
  input  wire logic [31:0]    sync_margin,
  input  wire logic [31:0]    unset_marker,
  input  wire logic           init_mode,
  output rcwt_pkg::result_t   res,
  output rcwt_pkg::update_t   upd
);

  logic [32:0] top_sum;
  logic        wrap;
  logic        above;
  logic        below;
  logic        in_win;
  logic        push_ok;
  logic [31:0] bumped;

  always_comb begin
    top_sum = {1'b0, last} + {1'b0, sync_margin};
    wrap    = top_sum[32];
    above   = code > last;
    below   = code <= top_sum[31:0];
    in_win  = wrap ? (above || below) : (above && below);
    push_ok = (init_mode && (last == unset_marker)) || in_win;
    bumped  = (init_mode && (code == unset_marker)) ? code + 32'd1 : code;

    res = '0;
    upd = '0;
    unique case (op)
      rcwt_pkg::OP_PUSH: begin
        if (slot_ok && push_ok) begin
          res.accepted     = 1'b1;
          res.command_out  = command;
          res.changed      = 1'b1;
          res.changed_slot = slot;
          res.new_code     = bumped;
          upd.we           = 1'b1;
          upd.data         = bumped;
        end
      end
      rcwt_pkg::OP_SYNC: begin
        if (slot_ok) begin
          res.changed      = 1'b1;
          res.changed_slot = slot;
          res.new_code     = bumped;
          upd.we           = 1'b1;
          upd.data         = bumped;
        end
      end
      rcwt_pkg::OP_LOAD: begin
        upd.we   = slot_ok;
        upd.data = code;
      end
      rcwt_pkg::OP_CLEAR: begin
        // sweep already done by the controller; nothing to report
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/rolling_code_window_tracker_core.sv]
// rolling_code_window_tracker_core: top level, sequencer, config registers, output register.
// Depends on rcwt_pkg, rcwt_slot_ram, rcwt_check.
//
//  channel  | signals                       | payload (low bit up)
//  ---------+-------------------------------+----------------------------------------
//  input    | s_tvalid s_tready s_tdata/user| tdata: slot, code, command; tuser: opcode
//  output   | m_tvalid m_tready m_tdata/user| tdata: command_out, changed_slot, new_code;
//           |                               | tuser: accepted, changed
//  config   | cfg_we cfg_index cfg_data     | 0 num_slots, 1 sync_margin, 2 unset_marker
//
// Push, sync and load first read the slot RAM, then check and write back.
// Clear-all sweeps all MAX_SLOTS slots of the RAM one slot a cycle.
// One transaction in flight at a time; a new one is taken while the last result waits.
// A stalled output holds the finished item in its check cycle until the register frees up.
// Reset is synchronous; slot contents are undefined until loaded, synced or cleared.
`default_nettype none

module rolling_code_window_tracker_core #(
  parameter int MAX_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // slot[7:0], code[39:8], command[47:40]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // command_out[7:0], changed_slot[15:8], new_code[47:16]
  output logic [1:0]       m_tuser,   // accepted[0], changed[1]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SLOTS - 1);

  rcwt_pkg::state_t  state;
  logic [4:0]        num_slots;
  logic [31:0]       sync_margin;
  logic [31:0]       unset_marker;
  logic              init_mode;
  logic [AW-1:0]     clr_cnt;

  rcwt_pkg::op_t     op;
  logic [7:0]        slot;
  logic [31:0]       code;
  logic [7:0]        command;
  logic              slot_ok;
  rcwt_pkg::result_t out_res;

  logic              accept;
  logic              out_free;
  logic              finish;
  logic              in_ok;
  logic [31:0]       rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  rcwt_pkg::result_t res;
  rcwt_pkg::update_t upd;

  assign s_tready = (state == rcwt_pkg::ST_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == rcwt_pkg::ST_RD) && out_free;
  assign in_ok    = ({3'b000, s_tdata[7:0]} < {6'd0, num_slots}) &&
                    ({1'b0, s_tdata[7:0]} < 9'(MAX_SLOTS));

  assign m_tdata  = {out_res.new_code, out_res.changed_slot, out_res.command_out};
  assign m_tuser  = {out_res.changed, out_res.accepted};

  always_comb begin
    if (state == rcwt_pkg::ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = unset_marker;
    end else begin
      ram_we    = finish && upd.we;
      ram_waddr = slot[AW-1:0];
      ram_wdata = upd.data;
    end
  end

  rcwt_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (s_tdata[AW-1:0]),
    .rdata (rdata)
  );

  rcwt_check u_check (
    .op           (op),
    .slot_ok      (slot_ok),
    .slot         (slot),
    .code         (code),
    .command      (command),
    .last         (rdata),
    .sync_margin  (sync_margin),
    .unset_marker (unset_marker),
    .init_mode    (init_mode),
    .res          (res),
    .upd          (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rcwt_pkg::ST_IDLE;
      m_tvalid     <= 1'b0;
      init_mode    <= 1'b0;
      clr_cnt      <= '0;
      num_slots    <= rcwt_pkg::NUM_SLOTS_RST;
      sync_margin  <= rcwt_pkg::SYNC_MARGIN_RST;
      unset_marker <= rcwt_pkg::UNSET_MARKER_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rcwt_pkg::CFG_NUM_SLOTS:    num_slots    <= cfg_data[4:0];
          rcwt_pkg::CFG_SYNC_MARGIN:  sync_margin  <= cfg_data;
          rcwt_pkg::CFG_UNSET_MARKER: unset_marker <= cfg_data;
          default: begin
          end
        endcase
      end

      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        rcwt_pkg::ST_IDLE: begin
          if (accept) begin
            clr_cnt <= '0;
            state   <= (rcwt_pkg::op_t'(s_tuser) == rcwt_pkg::OP_CLEAR) ?
                       rcwt_pkg::ST_CLR : rcwt_pkg::ST_RD;
          end
        end
        rcwt_pkg::ST_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_IDX) begin
            init_mode <= 1'b1;
            state     <= rcwt_pkg::ST_RD;
          end
        end
        rcwt_pkg::ST_RD: begin
          if (out_free) begin
            state <= rcwt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= rcwt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // item fields and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= rcwt_pkg::op_t'(s_tuser);
      slot    <= s_tdata[7:0];
      code    <= s_tdata[39:8];
      command <= s_tdata[47:40];
      slot_ok <= in_ok;
    end
    if (finish) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

[bench/tb.sv]
// tb: self-checking bench for rolling_code_window_tracker_core, with a scoreboard class that
// predicts the per-slot window check and stream drivers with random idling on both sides.
// Depends on rcwt_pkg and rolling_code_window_tracker_core.
`timescale 1ns / 100ps

module tb;

  localparam int SLOTS       = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_TARGET = 1450;
  localparam int CALM_AFTER  = 1250;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // slot[7:0], code[39:8], command[47:40]
  logic [1:0]  s_tuser;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // command_out[7:0], changed_slot[15:8], new_code[47:16]
  logic [1:0]  m_tuser;   // accepted[0], changed[1]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  rolling_code_window_tracker_core #(.MAX_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  class window_scoreboard;
    logic [4:0]         num_slots;
    logic [31:0]        margin;
    logic [31:0]        marker;
    logic [31:0]        codes [SLOTS];
    bit                 written [SLOTS];
    bit                 init_mode;
    rcwt_pkg::result_t  pending_q [$];
    int                 errors;

    function new();
      num_slots = rcwt_pkg::NUM_SLOTS_RST;
      margin    = rcwt_pkg::SYNC_MARGIN_RST;
      marker    = rcwt_pkg::UNSET_MARKER_RST;
      init_mode = 1'b0;
      errors    = 0;
      foreach (codes[i]) begin
        codes[i]   = '0;
        written[i] = 1'b0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        rcwt_pkg::CFG_NUM_SLOTS:    num_slots = data[4:0];
        rcwt_pkg::CFG_SYNC_MARGIN:  margin = data;
        rcwt_pkg::CFG_UNSET_MARKER: marker = data;
        default: ;
      endcase
    endfunction

    function bit slot_live(logic [7:0] s);
      return (s < num_slots) && (s < SLOTS);
    endfunction

    // forward window (last, last + margin], mod 2^32
    function bit in_window(logic [31:0] last, logic [31:0] c);
      logic [31:0] top;
      top = last + margin;
      if (top < last) return (c > last) || (c <= top);
      return (c > last) && (c <= top);
    endfunction

    function void note_input(rcwt_pkg::op_t op, logic [7:0] s, logic [31:0] c,
                             logic [7:0] cmd);
      rcwt_pkg::result_t r;
      logic [31:0]       stored;
      r = '0;
      if (op == rcwt_pkg::OP_CLEAR) begin
        foreach (codes[i]) begin
          codes[i]   = marker;
          written[i] = 1'b1;
        end
        init_mode = 1'b1;
      end else if (slot_live(s)) begin
        if (op == rcwt_pkg::OP_LOAD) begin
          codes[s[3:0]]   = c;
          written[s[3:0]] = 1'b1;
        end else if (op == rcwt_pkg::OP_SYNC || (init_mode && codes[s[3:0]] == marker) ||
                     in_window(codes[s[3:0]], c)) begin
          if (op == rcwt_pkg::OP_PUSH) begin
            r.accepted    = 1'b1;
            r.command_out = cmd;
          end
          stored = (init_mode && c == marker) ? c + 32'd1 : c;
          codes[s[3:0]]   = stored;
          written[s[3:0]] = 1'b1;
          r.changed      = 1'b1;
          r.changed_slot = s;
          r.new_code     = stored;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
    endfunction

    function void check_result(rcwt_pkg::result_t got);
      rcwt_pkg::result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result transaction with nothing pending: %h", got);
        return;
      end
      want = pending_q.pop_front();
      cmp("accepted", want.accepted, got.accepted);
      cmp("command_out", want.command_out, got.command_out);
      cmp("changed", want.changed, got.changed);
      cmp("changed_slot", want.changed_slot, got.changed_slot);
      cmp("new_code", want.new_code, got.new_code);
    endfunction
  endclass

  window_scoreboard sb;
  bit calm;
  int counted;
  int quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stall bursts, none once calm
  initial begin
    bit lvl;
    int n;
    m_tready <= 1'b0;
    forever begin
      lvl = calm || ($urandom_range(0, 2) != 0);
      n = lvl ? $urandom_range(1, 20) : $urandom_range(1, 13);
      repeat (n) begin
        @(posedge clk);
        m_tready <= lvl;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result('{accepted: m_tuser[0], command_out: m_tdata[7:0], changed: m_tuser[1],
                        changed_slot: m_tdata[15:8], new_code: m_tdata[47:16]});
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task send(rcwt_pkg::op_t op, logic [7:0] s, logic [31:0] c, logic [7:0] cmd);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {cmd, c, s};
    s_tuser  <= op;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_input(op, s, c, cmd);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
  endtask

  // drain, then program all three registers while idle
  task set_config(logic [31:0] count, logic [31:0] margin, logic [31:0] marker);
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    write_reg(rcwt_pkg::CFG_NUM_SLOTS, count);
    write_reg(rcwt_pkg::CFG_SYNC_MARGIN, margin);
    write_reg(rcwt_pkg::CFG_UNSET_MARKER, marker);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task make_item(output rcwt_pkg::op_t op, output logic [7:0] s, output logic [31:0] c,
                 output logic [7:0] cmd, input bit allow_clear);
    int          pick;
    int          lim;
    logic [31:0] last;
    lim  = (sb.num_slots < SLOTS) ? sb.num_slots : SLOTS;
    pick = $urandom_range(0, 99);
    cmd  = 8'($urandom);
    c    = $urandom;
    s    = (lim > 0) ? 8'($urandom_range(0, lim - 1)) : 8'($urandom_range(0, 255));
    last = sb.codes[s[3:0]];
    if (pick < 55) begin
      // in-window push
      op = rcwt_pkg::OP_PUSH;
      case ($urandom_range(0, 3))
        0: c = last + 32'd1;
        1: c = last + sb.margin;
        default: begin
          c = last + 32'd1;
          if (sb.margin != 0) c = c + ($urandom % sb.margin);
        end
      endcase
    end else if (pick < 65) begin
      // replay or out-of-window push
      op = rcwt_pkg::OP_PUSH;
      case ($urandom_range(0, 2))
        0: c = last;
        1: c = last + sb.margin + 32'd1;
        default: c = last - $urandom_range(1, 1000);
      endcase
    end else if (pick < 75) begin
      op = rcwt_pkg::OP_SYNC;
      if ($urandom_range(0, 3) == 0) c = sb.marker;
    end else if (pick < 85) begin
      op = rcwt_pkg::OP_LOAD;
      if ($urandom_range(0, 2) == 0) c = sb.marker;
    end else if (pick < 88 && allow_clear) begin
      op = rcwt_pkg::OP_CLEAR;
    end else begin
      op = rcwt_pkg::op_t'($urandom_range(0, 3));
      s  = 8'($urandom_range(0, 255));
      if (op == rcwt_pkg::OP_CLEAR && !allow_clear) op = rcwt_pkg::OP_SYNC;
    end
    // never read a slot that holds nothing yet
    if (op == rcwt_pkg::OP_PUSH && sb.slot_live(s) && !sb.written[s[3:0]])
      op = rcwt_pkg::OP_LOAD;
  endtask

  task run_phase(int target, bit allow_clear);
    int            got;
    int            sent;
    rcwt_pkg::op_t op;
    logic [7:0]    s;
    logic [7:0]    cmd;
    logic [31:0]   c;
    got  = 0;
    sent = 0;
    while (got < target && sent < 4 * target) begin
      make_item(op, s, c, cmd, allow_clear);
      if (op == rcwt_pkg::OP_CLEAR || sb.slot_live(s)) got++;
      sent++;
      counted++;
      if (counted >= CALM_AFTER) calm = 1'b1;
      send(op, s, c, cmd);
    end
  endtask

  initial begin
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= rcwt_pkg::OP_PUSH;
    cfg_we    <= 1'b0;
    cfg_index <= rcwt_pkg::CFG_NUM_SLOTS;
    cfg_data  <= '0;
    rst       <= 1'b1;
    calm    = 1'b0;
    counted = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, auto-init off: wrapping window, edges, replay, ignored slots
    send(rcwt_pkg::OP_LOAD, 8'd0, 32'hFFFF_FF80, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd0, 32'h0000_007F, 8'h3C);
    send(rcwt_pkg::OP_PUSH, 8'd0, 32'h0000_007F, 8'h11);
    send(rcwt_pkg::OP_PUSH, 8'd0, 32'h0000_0180, 8'h22);
    send(rcwt_pkg::OP_PUSH, 8'd0, 32'h0000_017F, 8'hFF);
    send(rcwt_pkg::OP_LOAD, 8'd15, 32'h0000_0000, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd15, 32'h0000_0000, 8'h44);
    send(rcwt_pkg::OP_SYNC, 8'd15, 32'hFFFF_FFFF, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd16, 32'h0000_0001, 8'h55);
    send(rcwt_pkg::OP_LOAD, 8'd255, 32'hDEAD_BEEF, 8'h00);
    send(rcwt_pkg::OP_SYNC, 8'd200, 32'h0000_0010, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd255, 32'hFFFF_FFFF, 8'hAA);
    run_phase(150, 1'b0);

    // clear-all turns auto-init on: unset acceptance and marker bump
    send(rcwt_pkg::OP_CLEAR, 8'd0, 32'h0, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd3, 32'h0000_0000, 8'h81);
    send(rcwt_pkg::OP_PUSH, 8'd3, 32'h0000_0001, 8'h82);
    send(rcwt_pkg::OP_SYNC, 8'd4, 32'h0000_0000, 8'h00);
    send(rcwt_pkg::OP_LOAD, 8'd5, 32'h0000_0000, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd5, 32'h1234_5678, 8'h5A);
    send(rcwt_pkg::OP_PUSH, 8'd7, 32'hFFFF_FFFF, 8'hA5);
    run_phase(150, 1'b1);

    set_config(32'd1, 32'h0, 32'hFFFF_FFFF);
    send(rcwt_pkg::OP_CLEAR, 8'd0, 32'h0, 8'h00);
    send(rcwt_pkg::OP_PUSH, 8'd0, 32'hFFFF_FFFF, 8'h01);
    run_phase(150, 1'b1);
    set_config(32'd16, 32'hFFFF_FFFF, 32'h0);
    run_phase(150, 1'b1);
    set_config(32'd8, 32'd1, 32'h8000_0000);
    run_phase(150, 1'b1);
    set_config(32'd0, 32'd1000, 32'd5);
    run_phase(40, 1'b1);
    set_config(32'd31, 32'd100, 32'd123);
    run_phase(150, 1'b1);

    while (counted < ITEM_TARGET) begin
      set_config($urandom_range(1, 16),
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000),
                 $urandom);
      run_phase((ITEM_TARGET - counted < 150) ? ITEM_TARGET - counted : 150, 1'b1);
    end

    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
